[design/irv_pkg.sv]
// ----------------------------------------------------------------------------
// irv_pkg
// Shared constants and types for the identity record verifier.
// ----------------------------------------------------------------------------
package irv_pkg;

   // Record layout
   localparam int ADDRESS_BYTES  = 6;
   localparam int SUM_BYTES      = 7 + ADDRESS_BYTES;
   localparam int RECORD_BYTES   = 11 + ADDRESS_BYTES;
   localparam int POS_WIDTH      = $clog2(RECORD_BYTES + 1);
   localparam int ADDR_WIDTH     = 48;
   localparam int MAGIC_POS      = 0;
   localparam int VERSION_POS    = 4;
   localparam int VALID_POS      = 6;
   localparam int ADDR_FIRST_POS = 7;

   localparam logic [31:0] CHECK_XOR = 32'hB1E1_D7A9;
   localparam logic [7:0]  TOP_BITS  = 8'hC0;
   localparam logic [7:0]  BYTE_ONES = 8'hFF;
   localparam logic [7:0]  BYTE_ZERO = 8'h00;
   localparam logic [7:0]  VALID_MARK = 8'h01;

   // Status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_BAD_MAGIC   = 3'd1;
   localparam logic [2:0] STATUS_BAD_VERSION = 3'd2;
   localparam logic [2:0] STATUS_NOT_VALID   = 3'd3;
   localparam logic [2:0] STATUS_BAD_CHECK   = 3'd4;
   localparam logic [2:0] STATUS_BAD_ADDRESS = 3'd5;

   // Register indexes
   localparam logic REG_MAGIC   = 1'b0;
   localparam logic REG_VERSION = 1'b1;

   typedef struct packed {
      logic                  last;
      logic [2:0]            status;
      logic [ADDR_WIDTH-1:0] address;
   } irv_result_type;

endpackage

[design/irv_parser.sv]
// ----------------------------------------------------------------------------
// irv_parser
// Parse state for one record, rotating checksum and final checks.
// ----------------------------------------------------------------------------
module irv_parser import irv_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     record_byte,
   input  logic           first_byte,
   input  logic [31:0]    expected_magic,
   input  logic [15:0]    expected_version,
   output irv_result_type result
);

   logic [POS_WIDTH-1:0]  pos_ff, pos_in, base_pos;
   logic [31:0]           sum_ff, sum_in, base_sum, sum_add;
   logic [31:0]           magic_ff, magic_in, base_magic;
   logic [15:0]           version_ff, version_in, base_version;
   logic [7:0]            valid_ff, valid_in, base_valid;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in, base_addr;
   logic [7:0]            lead_ff, lead_in, base_lead;
   logic [31:0]           check_ff, check_in, base_check;
   logic                  all_zero_ff, all_zero_in, base_all_zero;
   logic                  all_ones_ff, all_ones_in, base_all_ones;
   logic                  in_range;
   logic [POS_WIDTH-1:0]  check_off;
   logic [2:0]            status;

   always_comb begin
      // a first byte restarts parsing from a clean state
      base_pos      = first_byte ? '0 : pos_ff;
      base_sum      = first_byte ? '0 : sum_ff;
      base_magic    = first_byte ? '0 : magic_ff;
      base_version  = first_byte ? '0 : version_ff;
      base_valid    = first_byte ? '0 : valid_ff;
      base_addr     = first_byte ? '0 : addr_ff;
      base_lead     = first_byte ? '0 : lead_ff;
      base_check    = first_byte ? '0 : check_ff;
      base_all_zero = first_byte ? 1'b1 : all_zero_ff;
      base_all_ones = first_byte ? 1'b1 : all_ones_ff;

      in_range  = base_pos < POS_WIDTH'(RECORD_BYTES);
      check_off = base_pos - POS_WIDTH'(SUM_BYTES);
      sum_add   = base_sum + {24'd0, record_byte};

      pos_in      = base_pos;
      sum_in      = base_sum;
      magic_in    = base_magic;
      version_in  = base_version;
      valid_in    = base_valid;
      addr_in     = base_addr;
      lead_in     = base_lead;
      check_in    = base_check;
      all_zero_in = base_all_zero;
      all_ones_in = base_all_ones;

      if (in_range) begin
         pos_in = base_pos + 1'b1;
         if (base_pos < POS_WIDTH'(VERSION_POS)) begin
            magic_in = base_magic | ({24'd0, record_byte} << {base_pos[1:0], 3'b000});
         end else if (base_pos < POS_WIDTH'(VALID_POS)) begin
            version_in = base_version | ({8'd0, record_byte} << {base_pos[0], 3'b000});
         end else if (base_pos == POS_WIDTH'(VALID_POS)) begin
            valid_in = record_byte;
         end else if (base_pos < POS_WIDTH'(SUM_BYTES)) begin
            addr_in = {base_addr[ADDR_WIDTH-9:0], record_byte};
            if (base_pos == POS_WIDTH'(ADDR_FIRST_POS)) begin
               lead_in = record_byte;
            end
            if (record_byte != BYTE_ZERO) begin
               all_zero_in = 1'b0;
            end
            if (record_byte != BYTE_ONES) begin
               all_ones_in = 1'b0;
            end
         end else begin
            check_in = base_check | ({24'd0, record_byte} << {check_off[1:0], 3'b000});
         end
         if (base_pos < POS_WIDTH'(SUM_BYTES)) begin
            sum_in = {sum_add[28:0], sum_add[31:29]};
         end
      end
   end

   // Checks on the state as it stands after the last byte
   always_comb begin
      if (magic_in != expected_magic) begin
         status = STATUS_BAD_MAGIC;
      end else if (version_in != expected_version) begin
         status = STATUS_BAD_VERSION;
      end else if (valid_in != VALID_MARK) begin
         status = STATUS_NOT_VALID;
      end else if (check_in != (sum_in ^ CHECK_XOR)) begin
         status = STATUS_BAD_CHECK;
      end else if (all_zero_in || all_ones_in || ((lead_in & TOP_BITS) != TOP_BITS)) begin
         status = STATUS_BAD_ADDRESS;
      end else begin
         status = STATUS_OK;
      end
      result.last    = in_range && (base_pos == POS_WIDTH'(RECORD_BYTES - 1));
      result.status  = status;
      result.address = (status == STATUS_OK) ? addr_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         sum_ff      <= '0;
         magic_ff    <= '0;
         version_ff  <= '0;
         valid_ff    <= '0;
         addr_ff     <= '0;
         lead_ff     <= '0;
         check_ff    <= '0;
         all_zero_ff <= 1'b1;
         all_ones_ff <= 1'b1;
      end else if (step) begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         magic_ff    <= magic_in;
         version_ff  <= version_in;
         valid_ff    <= valid_in;
         addr_ff     <= addr_in;
         lead_ff     <= lead_in;
         check_ff    <= check_in;
         all_zero_ff <= all_zero_in;
         all_ones_ff <= all_ones_in;
      end
   end

endmodule

[design/identity_record_verifier_top.sv]
// ----------------------------------------------------------------------------
// identity_record_verifier_top
// Checks a stored identity record fed one byte per transfer and reports
// status and address on the record's last byte.
// ----------------------------------------------------------------------------
//   channel   direction   carries
//   req_*     in          record_byte, first_byte
//   rsp_*     out         status, address (one per completed record)
//   csr_*     in/out      expected_magic (0x0), expected_version (0x4)
//
// One byte per cycle but for the stall below. A byte is held in the input
// register; a record's result loads into the output register as its last
// byte steps. The parse state is a single pass over the input register per
// byte. A stalled result holds back the next record's last byte and those
// behind it. Synchronous reset clears parse state, CSRs and valid flags.
// ----------------------------------------------------------------------------
module identity_record_verifier_top import irv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_record_byte,
   input  logic                  req_first_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [ADDR_WIDTH-1:0] rsp_address,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [31:0]           magic_ff;
   logic [15:0]           version_ff;
   logic                  csr_write;
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   logic                  in_first_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [2:0]            out_status_ff;
   logic [ADDR_WIDTH-1:0] out_address_ff;
   logic                  out_load, step, req_fire;
   irv_result_type        result;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= '0;
         version_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_MAGIC:   magic_ff   <= csr_pwdata;
            REG_VERSION: version_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_MAGIC:   csr_prdata = magic_ff;
         REG_VERSION: csr_prdata = {16'd0, version_ff};
         default:     csr_prdata = '0;
      endcase
   end

   irv_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .record_byte      (in_byte_ff),
      .first_byte       (in_first_ff),
      .expected_magic   (magic_ff),
      .expected_version (version_ff),
      .result           (result)
   );

   // Only a byte that completes a record needs room in the output register
   assign out_load  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && (!result.last || out_load);
   assign req_ready = !in_valid_ff || step;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step && result.last) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_record_byte;
         in_first_ff <= req_first_byte;
      end
      if (step && result.last) begin
         out_status_ff  <= result.status;
         out_address_ff <= result.address;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_address = out_address_ff;

endmodule
